// ===== design/ole_pkg.sv =====
// Shared types for the ordered list engine: command and status codes, datapath select
// codes, controller-to-datapath control struct and datapath status struct. No dependencies.
package ole_pkg;

  typedef enum logic [3:0] {
    CMD_INS_HEAD  = 4'd0,
    CMD_INS_TAIL  = 4'd1,
    CMD_INS_AFTER = 4'd2,
    CMD_LIST      = 4'd3,
    CMD_DEL_HEAD  = 4'd4,
    CMD_DEL_TAIL  = 4'd5,
    CMD_DEL_AT    = 4'd6,
    CMD_SORT_UP   = 4'd7,
    CMD_SORT_DN   = 4'd8
  } cmd_e;

  typedef enum logic [1:0] {
    ST_OK       = 2'd0,
    ST_EMPTY    = 2'd1,
    ST_NOTFOUND = 2'd2,
    ST_FULL     = 2'd3
  } stat_e;

  typedef enum logic [2:0] {
    AT_HOLD, AT_ZERO, AT_CNT, AT_POS, AT_POS_M1, AT_CNT_M1
  } at_sel_e;

  typedef enum logic [2:0] {
    K_HOLD, K_CNT, K_ZERO, K_AT, K_I, K_DEC, K_INC
  } k_op_e;

  typedef enum logic [1:0] {
    I_HOLD, I_ONE, I_INC
  } i_op_e;

  typedef enum logic [2:0] {
    RA_K, RA_KM1, RA_KP1, RA_AT, RA_I
  } rd_addr_e;

  typedef enum logic {
    WA_K, WA_AT
  } wr_addr_e;

  typedef enum logic [1:0] {
    WD_RDATA, WD_VAL, WD_KEY
  } wr_data_e;

  typedef enum logic [1:0] {
    OI_ZERO, OI_KEY, OI_RDATA
  } out_item_e;

  typedef struct packed {
    logic      load_in;
    at_sel_e   at_sel;
    k_op_e     k_op;
    i_op_e     i_op;
    logic      rd_en;
    rd_addr_e  rd_addr;
    logic      wr_en;
    wr_addr_e  wr_addr;
    wr_data_e  wr_data;
    logic      key_load;
    logic      cnt_inc;
    logic      cnt_dec;
    logic      out_load;
    out_item_e out_item;
    stat_e     out_status;
    logic      out_last;
  } ole_ctl_t;

  typedef struct packed {
    logic [3:0] cmd;
    logic       empty;
    logic       full;
    logic       pos_bad;
    logic       k_gt_at;
    logic       k1_lt_cnt;
    logic       k_last;
    logic       k_zero;
    logic       i_lt_cnt;
    logic       move;
    logic       out_free;
  } ole_sts_t;

endpackage

// ===== design/ole_dpath.sv =====
// Datapath of the ordered list engine: entry memory, count, index registers
// and the output word register. Depends on ole_pkg.
module ole_dpath import ole_pkg::*; #(
  parameter int CAPACITY = 16
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  ole_ctl_t           ctl_i,
  output ole_sts_t           sts_o,
  input  logic [3:0]         command_i,
  input  logic [7:0]         position_i,
  input  logic signed [31:0] value_i,
  output logic               out_valid_o,
  input  logic               out_stall_i,
  output logic signed [31:0] item_value_o,
  output logic [1:0]         status_o,
  output logic               last_of_run_o
);

  localparam int AW = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
  localparam int CW = $clog2(CAPACITY + 1);

  logic [31:0]       mem_q [CAPACITY];
  logic [31:0]       rdata_q;
  logic [3:0]        cmd_q;
  logic [7:0]        pos_q;
  logic [31:0]       val_q;
  logic [31:0]       key_q;
  logic [CW-1:0]     cnt_q, cnt_d;
  logic [CW-1:0]     k_q, k_d;
  logic [CW-1:0]     i_q, i_d;
  logic [CW-1:0]     at_q, at_d;
  logic [CW-1:0]     ra, wa, k_m1, k_p1;
  logic [31:0]       wdata, item_d;
  logic              ovalid_q, ovalid_d;
  logic [31:0]       item_q;
  stat_e             ostat_q;
  logic              olast_q;

  assign k_m1 = k_q - CW'(1);
  assign k_p1 = k_q + CW'(1);

  always_comb begin
    case (ctl_i.at_sel)
      AT_ZERO:   at_d = '0;
      AT_CNT:    at_d = cnt_q;
      AT_POS:    at_d = pos_q[CW-1:0];
      AT_POS_M1: at_d = pos_q[CW-1:0] - CW'(1);
      AT_CNT_M1: at_d = cnt_q - CW'(1);
      default:   at_d = at_q;
    endcase
    case (ctl_i.k_op)
      K_CNT:   k_d = cnt_q;
      K_ZERO:  k_d = '0;
      K_AT:    k_d = at_q;
      K_I:     k_d = i_q;
      K_DEC:   k_d = k_m1;
      K_INC:   k_d = k_p1;
      default: k_d = k_q;
    endcase
    case (ctl_i.i_op)
      I_ONE:   i_d = CW'(1);
      I_INC:   i_d = i_q + CW'(1);
      default: i_d = i_q;
    endcase
    case (ctl_i.rd_addr)
      RA_KM1:  ra = k_m1;
      RA_KP1:  ra = k_p1;
      RA_AT:   ra = at_q;
      RA_I:    ra = i_q;
      default: ra = k_q;
    endcase
    wa = (ctl_i.wr_addr == WA_AT) ? at_q : k_q;
    case (ctl_i.wr_data)
      WD_VAL:  wdata = val_q;
      WD_KEY:  wdata = key_q;
      default: wdata = rdata_q;
    endcase
    case (ctl_i.out_item)
      OI_KEY:   item_d = key_q;
      OI_RDATA: item_d = rdata_q;
      default:  item_d = '0;
    endcase
    cnt_d = cnt_q;
    if (ctl_i.cnt_inc) cnt_d = cnt_q + CW'(1);
    else if (ctl_i.cnt_dec) cnt_d = cnt_q - CW'(1);
    ovalid_d = ovalid_q;
    if (ctl_i.out_load) ovalid_d = 1'b1;
    else if (!out_stall_i) ovalid_d = 1'b0;
  end

  always_ff @(posedge clk_i) begin
    if (ctl_i.wr_en) mem_q[wa[AW-1:0]] <= wdata;
    if (ctl_i.rd_en) rdata_q <= mem_q[ra[AW-1:0]];
    if (ctl_i.load_in) begin
      cmd_q <= command_i;
      pos_q <= position_i;
      val_q <= value_i;
    end
    if (ctl_i.key_load) key_q <= rdata_q;
    if (ctl_i.out_load) begin
      item_q  <= item_d;
      ostat_q <= ctl_i.out_status;
      olast_q <= ctl_i.out_last;
    end
    k_q  <= k_d;
    i_q  <= i_d;
    at_q <= at_d;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q    <= '0;
      ovalid_q <= 1'b0;
    end else begin
      cnt_q    <= cnt_d;
      ovalid_q <= ovalid_d;
    end
  end

  always_comb begin
    sts_o.cmd       = cmd_q;
    sts_o.empty     = (cnt_q == '0);
    sts_o.full      = (cnt_q == CW'(CAPACITY));
    sts_o.pos_bad   = (pos_q == 8'd0) || (pos_q > 8'(cnt_q));
    sts_o.k_gt_at   = (k_q > at_q);
    sts_o.k1_lt_cnt = (k_p1 < cnt_q);
    sts_o.k_last    = (k_p1 == cnt_q);
    sts_o.k_zero    = (k_q == '0);
    sts_o.i_lt_cnt  = (i_q < cnt_q);
    sts_o.move      = (cmd_q == CMD_SORT_UP) ? ($signed(key_q) < $signed(rdata_q))
                                             : ($signed(rdata_q) < $signed(key_q));
    sts_o.out_free  = !ovalid_q || !out_stall_i;
  end

  assign out_valid_o   = ovalid_q;
  assign item_value_o  = item_q;
  assign status_o      = ostat_q;
  assign last_of_run_o = olast_q;

endmodule

// ===== design/ole_ctrl.sv =====
// Controller of the ordered list engine: sequences shifts, deletes, list
// walks and insertion sort over the datapath. Depends on ole_pkg.
module ole_ctrl import ole_pkg::*; (
  input  logic     clk_i,
  input  logic     rst_ni,
  input  logic     in_valid_i,
  output logic     in_stall_o,
  input  ole_sts_t sts_i,
  output ole_ctl_t ctl_o
);

  typedef enum logic [16:0] {
    S_IDLE      = 17'h00001,
    S_DECODE    = 17'h00002,
    S_SHIFT_RD  = 17'h00004,
    S_SHIFT_WR  = 17'h00008,
    S_INS_WR    = 17'h00010,
    S_RESP      = 17'h00020,
    S_DEL_RD    = 17'h00040,
    S_DEL_CAP   = 17'h00080,
    S_DEL_MV_RD = 17'h00100,
    S_DEL_MV_WR = 17'h00200,
    S_LIST_RD   = 17'h00400,
    S_LIST_OUT  = 17'h00800,
    S_SORT_I    = 17'h01000,
    S_SORT_KEY  = 17'h02000,
    S_SORT_J    = 17'h04000,
    S_SORT_CMP  = 17'h08000,
    S_SORT_PUT  = 17'h10000
  } state_e;

  state_e state_q, state_d;
  stat_e  code_q, code_d;
  logic   rkey_q, rkey_d;

  assign in_stall_o = (state_q != S_IDLE);

  always_comb begin
    state_d = state_q;
    code_d  = code_q;
    rkey_d  = rkey_q;
    ctl_o   = '0;
    unique case (state_q)
      S_IDLE: begin
        if (in_valid_i) begin
          ctl_o.load_in = 1'b1;
          state_d = S_DECODE;
        end
      end
      S_DECODE: begin
        rkey_d = 1'b0;
        state_d = S_RESP;
        unique case (sts_i.cmd)
          CMD_INS_HEAD, CMD_INS_TAIL: begin
            if (sts_i.full) begin
              code_d = ST_FULL;
            end else begin
              ctl_o.at_sel = (sts_i.cmd == CMD_INS_HEAD) ? AT_ZERO : AT_CNT;
              ctl_o.k_op = K_CNT;
              state_d = S_SHIFT_RD;
            end
          end
          CMD_INS_AFTER: begin
            if (sts_i.empty) code_d = ST_EMPTY;
            else if (sts_i.pos_bad) code_d = ST_NOTFOUND;
            else if (sts_i.full) code_d = ST_FULL;
            else begin
              ctl_o.at_sel = AT_POS;
              ctl_o.k_op = K_CNT;
              state_d = S_SHIFT_RD;
            end
          end
          CMD_LIST: begin
            if (sts_i.empty) code_d = ST_EMPTY;
            else begin
              ctl_o.k_op = K_ZERO;
              state_d = S_LIST_RD;
            end
          end
          CMD_DEL_HEAD, CMD_DEL_TAIL: begin
            if (sts_i.empty) code_d = ST_EMPTY;
            else begin
              ctl_o.at_sel = (sts_i.cmd == CMD_DEL_HEAD) ? AT_ZERO : AT_CNT_M1;
              state_d = S_DEL_RD;
            end
          end
          CMD_DEL_AT: begin
            if (sts_i.empty) code_d = ST_EMPTY;
            else if (sts_i.pos_bad) code_d = ST_NOTFOUND;
            else begin
              ctl_o.at_sel = AT_POS_M1;
              state_d = S_DEL_RD;
            end
          end
          CMD_SORT_UP, CMD_SORT_DN: begin
            if (sts_i.empty) code_d = ST_EMPTY;
            else begin
              ctl_o.i_op = I_ONE;
              state_d = S_SORT_I;
            end
          end
          default: state_d = S_IDLE;
        endcase
      end
      S_SHIFT_RD: begin
        if (sts_i.k_gt_at) begin
          ctl_o.rd_en = 1'b1;
          ctl_o.rd_addr = RA_KM1;
          state_d = S_SHIFT_WR;
        end else begin
          state_d = S_INS_WR;
        end
      end
      S_SHIFT_WR: begin
        ctl_o.wr_en = 1'b1;
        ctl_o.wr_addr = WA_K;
        ctl_o.wr_data = WD_RDATA;
        ctl_o.k_op = K_DEC;
        state_d = S_SHIFT_RD;
      end
      S_INS_WR: begin
        ctl_o.wr_en = 1'b1;
        ctl_o.wr_addr = WA_AT;
        ctl_o.wr_data = WD_VAL;
        ctl_o.cnt_inc = 1'b1;
        code_d = ST_OK;
        state_d = S_RESP;
      end
      S_RESP: begin
        if (sts_i.out_free) begin
          ctl_o.out_load = 1'b1;
          ctl_o.out_item = rkey_q ? OI_KEY : OI_ZERO;
          ctl_o.out_status = code_q;
          ctl_o.out_last = 1'b1;
          state_d = S_IDLE;
        end
      end
      S_DEL_RD: begin
        ctl_o.rd_en = 1'b1;
        ctl_o.rd_addr = RA_AT;
        state_d = S_DEL_CAP;
      end
      S_DEL_CAP: begin
        ctl_o.key_load = 1'b1;
        ctl_o.k_op = K_AT;
        state_d = S_DEL_MV_RD;
      end
      S_DEL_MV_RD: begin
        if (sts_i.k1_lt_cnt) begin
          ctl_o.rd_en = 1'b1;
          ctl_o.rd_addr = RA_KP1;
          state_d = S_DEL_MV_WR;
        end else begin
          ctl_o.cnt_dec = 1'b1;
          code_d = ST_OK;
          rkey_d = 1'b1;
          state_d = S_RESP;
        end
      end
      S_DEL_MV_WR: begin
        ctl_o.wr_en = 1'b1;
        ctl_o.wr_addr = WA_K;
        ctl_o.wr_data = WD_RDATA;
        ctl_o.k_op = K_INC;
        state_d = S_DEL_MV_RD;
      end
      S_LIST_RD: begin
        ctl_o.rd_en = 1'b1;
        ctl_o.rd_addr = RA_K;
        state_d = S_LIST_OUT;
      end
      S_LIST_OUT: begin
        if (sts_i.out_free) begin
          ctl_o.out_load = 1'b1;
          ctl_o.out_item = OI_RDATA;
          ctl_o.out_status = ST_OK;
          ctl_o.out_last = sts_i.k_last;
          ctl_o.k_op = K_INC;
          state_d = sts_i.k_last ? S_IDLE : S_LIST_RD;
        end
      end
      S_SORT_I: begin
        if (sts_i.i_lt_cnt) begin
          ctl_o.rd_en = 1'b1;
          ctl_o.rd_addr = RA_I;
          state_d = S_SORT_KEY;
        end else begin
          ctl_o.k_op = K_ZERO;
          state_d = S_LIST_RD;
        end
      end
      S_SORT_KEY: begin
        ctl_o.key_load = 1'b1;
        ctl_o.k_op = K_I;
        state_d = S_SORT_J;
      end
      S_SORT_J: begin
        if (!sts_i.k_zero) begin
          ctl_o.rd_en = 1'b1;
          ctl_o.rd_addr = RA_KM1;
          state_d = S_SORT_CMP;
        end else begin
          state_d = S_SORT_PUT;
        end
      end
      S_SORT_CMP: begin
        if (sts_i.move) begin
          ctl_o.wr_en = 1'b1;
          ctl_o.wr_addr = WA_K;
          ctl_o.wr_data = WD_RDATA;
          ctl_o.k_op = K_DEC;
          state_d = S_SORT_J;
        end else begin
          state_d = S_SORT_PUT;
        end
      end
      S_SORT_PUT: begin
        ctl_o.wr_en = 1'b1;
        ctl_o.wr_addr = WA_K;
        ctl_o.wr_data = WD_KEY;
        ctl_o.i_op = I_INC;
        state_d = S_SORT_I;
      end
      default: state_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
      code_q  <= ST_OK;
      rkey_q  <= 1'b0;
    end else begin
      state_q <= state_d;
      code_q  <= code_d;
      rkey_q  <= rkey_d;
    end
  end

endmodule

// ===== design/ordered_list_engine.sv =====
// Ordered list engine: accepts one command word at a time.
// Insert shifts later entries up, then writes; delete reads the entry, then shifts later ones down.
// Sort: insertion sort on the entry memory (separate read and write ports), then the list walk.
// Reset clears the entry count, output valid and controller state; entries need no clearing.
// Depends on ole_pkg, ole_ctrl, ole_dpath.
module ordered_list_engine import ole_pkg::*; #(
  parameter int CAPACITY = 16
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               in_valid_i,
  output logic               in_stall_o,
  input  logic [3:0]         command_i,
  input  logic [7:0]         position_i,
  input  logic signed [31:0] value_i,
  output logic               out_valid_o,
  input  logic               out_stall_i,
  output logic signed [31:0] item_value_o,
  output logic [1:0]         status_o,
  output logic               last_of_run_o
);

  ole_ctl_t ctl;
  ole_sts_t sts;

  ole_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_stall_o (in_stall_o),
    .sts_i      (sts),
    .ctl_o      (ctl)
  );

  ole_dpath #(
    .CAPACITY (CAPACITY)
  ) u_dpath (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .ctl_i         (ctl),
    .sts_o         (sts),
    .command_i     (command_i),
    .position_i    (position_i),
    .value_i       (value_i),
    .out_valid_o   (out_valid_o),
    .out_stall_i   (out_stall_i),
    .item_value_o  (item_value_o),
    .status_o      (status_o),
    .last_of_run_o (last_of_run_o)
  );

  a_out_free : assert property (@(posedge clk_i) disable iff (!rst_ni)
    ctl.out_load |-> sts.out_free) else $error("output word overwritten");

  a_cnt_dir : assert property (@(posedge clk_i) disable iff (!rst_ni)
    !(ctl.cnt_inc && ctl.cnt_dec)) else $error("count moved both ways");

  a_no_overfill : assert property (@(posedge clk_i) disable iff (!rst_ni)
    ctl.cnt_inc |-> !sts.full) else $error("insert into full list");

  a_busy : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_valid_i && !in_stall_o) |=> in_stall_o) else $error("not busy after accept");

endmodule

// ===== sim/ordered_list_checker.sv =====
// Checker for the ordered list engine: watches the command and result channels,
// keeps its own copy of the list, predicts results and counts mismatches.
// Depends on ole_pkg.
`timescale 1ns / 1ps
module ordered_list_checker import ole_pkg::*; #(
  parameter int CAPACITY = 16
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               in_valid_i,
  input  logic               in_stall_i,
  input  logic [3:0]         command_i,
  input  logic [7:0]         position_i,
  input  logic signed [31:0] value_i,
  input  logic               out_valid_i,
  input  logic               out_stall_i,
  input  logic signed [31:0] item_value_i,
  input  logic [1:0]         status_i,
  input  logic               last_of_run_i,
  output int                 fail_count_o,
  output int                 pending_o
);

  typedef struct packed {
    logic signed [31:0] item_value;
    stat_e              status;
    logic               last;
  } list_result_t;

  logic signed [31:0] list_words[CAPACITY];
  int                 list_len;
  list_result_t       expected_q[$];

  task automatic report_mismatch(input string what);
    $display("mismatch at %0t: %s", $realtime, what);
    fail_count_o++;
  endtask

  function automatic void push_result(logic signed [31:0] v, stat_e s, logic l);
    list_result_t r;
    r.item_value = v;
    r.status     = s;
    r.last       = l;
    expected_q.push_back(r);
  endfunction

  task automatic push_listing();
    if (list_len == 0) begin
      push_result(0, ST_EMPTY, 1'b1);
    end else begin
      for (int i = 0; i < list_len; i++) push_result(list_words[i], ST_OK, i == list_len - 1);
    end
  endtask

  task automatic insert_word(int at, logic signed [31:0] v);
    for (int k = list_len; k > at; k--) list_words[k] = list_words[k - 1];
    list_words[at] = v;
    list_len++;
  endtask

  task automatic remove_word(int at);
    push_result(list_words[at], ST_OK, 1'b1);
    for (int k = at; k + 1 < list_len; k++) list_words[k] = list_words[k + 1];
    list_len--;
  endtask

  task automatic sort_words(bit ascending);
    logic signed [31:0] key;
    int j;
    for (int i = 1; i < list_len; i++) begin
      key = list_words[i];
      j = i;
      while (j > 0 && (ascending ? key < list_words[j - 1] : list_words[j - 1] < key)) begin
        list_words[j] = list_words[j - 1];
        j--;
      end
      list_words[j] = key;
    end
  endtask

  task automatic predict_command(logic [3:0] cmd, int pos, logic signed [31:0] v);
    case (cmd)
      CMD_INS_HEAD, CMD_INS_TAIL: begin
        if (list_len >= CAPACITY) begin
          push_result(0, ST_FULL, 1'b1);
        end else begin
          insert_word(cmd == CMD_INS_HEAD ? 0 : list_len, v);
          push_result(0, ST_OK, 1'b1);
        end
      end
      CMD_INS_AFTER: begin
        if (list_len == 0) push_result(0, ST_EMPTY, 1'b1);
        else if (pos == 0 || pos > list_len) push_result(0, ST_NOTFOUND, 1'b1);
        else if (list_len >= CAPACITY) push_result(0, ST_FULL, 1'b1);
        else begin
          insert_word(pos, v);
          push_result(0, ST_OK, 1'b1);
        end
      end
      CMD_LIST: push_listing();
      CMD_DEL_HEAD, CMD_DEL_TAIL: begin
        if (list_len == 0) push_result(0, ST_EMPTY, 1'b1);
        else remove_word(cmd == CMD_DEL_HEAD ? 0 : list_len - 1);
      end
      CMD_DEL_AT: begin
        if (list_len == 0) push_result(0, ST_EMPTY, 1'b1);
        else if (pos == 0 || pos > list_len) push_result(0, ST_NOTFOUND, 1'b1);
        else remove_word(pos - 1);
      end
      CMD_SORT_UP, CMD_SORT_DN: begin
        sort_words(cmd == CMD_SORT_UP);
        push_listing();
      end
      default: ;
    endcase
  endtask

  always @(posedge clk_i or negedge rst_ni) begin
    list_result_t e;
    if (!rst_ni) begin
      list_len = 0;
      expected_q.delete();
      fail_count_o = 0;
      pending_o = 0;
    end else begin
      if (out_valid_i && !out_stall_i) begin
        if (expected_q.size() == 0) begin
          report_mismatch($sformatf("unexpected word %0d", item_value_i));
        end else begin
          e = expected_q.pop_front();
          if (item_value_i !== e.item_value)
            report_mismatch($sformatf("item_value %0d, want %0d", item_value_i, e.item_value));
          if (status_i !== e.status)
            report_mismatch($sformatf("status %0d, want %0d", status_i, e.status));
          if (last_of_run_i !== e.last)
            report_mismatch($sformatf("last_of_run %0b, want %0b", last_of_run_i, e.last));
        end
      end
      if (in_valid_i && !in_stall_i) predict_command(command_i, position_i, value_i);
      pending_o = expected_q.size();
    end
  end

endmodule

// ===== sim/ordered_list_engine_tb.sv =====
// Testbench top for the ordered list engine: drives commands and result stalls,
// instantiates the block and ordered_list_checker, and prints the verdict.
// Depends on ole_pkg, ordered_list_engine, ordered_list_checker.
`timescale 1ns / 1ps
module ordered_list_engine_tb;
  import ole_pkg::*;

  localparam int CAPACITY  = 16;
  localparam int IDLE_MAX  = 20000;

  logic               clk_i = 1'b0;
  logic               rst_ni = 1'b0;
  logic               in_valid_i = 1'b0;
  logic               in_stall_o;
  logic [3:0]         command_i = '0;
  logic [7:0]         position_i = '0;
  logic signed [31:0] value_i = '0;
  logic               out_valid_o;
  logic               out_stall_i = 1'b0;
  logic signed [31:0] item_value_o;
  logic [1:0]         status_o;
  logic               last_of_run_o;
  int                 fail_count;
  int                 pending;
  int                 idle_cycles = 0;
  bit                 hold_off = 1'b0;
  int                 model_len = 0;

  always begin
    #1 clk_i = 1'b1;
    #1 clk_i = 1'b0;
  end

  ordered_list_engine #(.CAPACITY(CAPACITY)) i_dut (.*);

  ordered_list_checker #(.CAPACITY(CAPACITY)) i_checker (
    .clk_i, .rst_ni, .in_valid_i, .in_stall_i(in_stall_o), .command_i, .position_i,
    .value_i, .out_valid_i(out_valid_o), .out_stall_i, .item_value_i(item_value_o),
    .status_i(status_o), .last_of_run_i(last_of_run_o), .fail_count_o(fail_count),
    .pending_o(pending)
  );

  function automatic int gap_length();
    int r;
    r = $urandom_range(0, 99);
    if (r < 55) return 0;
    if (r < 92) return $urandom_range(1, 3);
    return $urandom_range(8, 40);
  endfunction

  function automatic logic signed [31:0] random_value();
    case ($urandom_range(0, 5))
      0: return 32'sh7fffffff;
      1: return 32'sh80000000;
      2: return $urandom_range(0, 6) - 3;
      default: return $urandom;
    endcase
  endfunction

  task automatic send_word(logic [3:0] cmd, logic [7:0] pos, logic signed [31:0] v);
    int g;
    g = gap_length();
    if (g != 0) begin
      in_valid_i <= 1'b0;
      repeat (g) @(negedge clk_i);
    end
    in_valid_i <= 1'b1;
    command_i  <= cmd;
    position_i <= pos;
    value_i    <= v;
    do @(posedge clk_i); while (in_stall_o);
    @(negedge clk_i);
    case (cmd)
      CMD_INS_HEAD, CMD_INS_TAIL: if (model_len < CAPACITY) model_len++;
      CMD_INS_AFTER:
        if (model_len > 0 && pos != 0 && pos <= model_len && model_len < CAPACITY) model_len++;
      CMD_DEL_HEAD, CMD_DEL_TAIL: if (model_len > 0) model_len--;
      CMD_DEL_AT: if (model_len > 0 && pos != 0 && pos <= model_len) model_len--;
      default: ;
    endcase
  endtask

  task automatic send_random();
    int r;
    logic [7:0] pos;
    r = $urandom_range(0, 99);
    pos = ($urandom_range(0, 9) == 0) ? 8'($urandom) : 8'($urandom_range(0, model_len + 1));
    if (r < 3) send_word(4'($urandom_range(9, 15)), 8'($urandom), $urandom);
    else if (r < 18) send_word(CMD_INS_HEAD, pos, random_value());
    else if (r < 33) send_word(CMD_INS_TAIL, pos, random_value());
    else if (r < 48) send_word(CMD_INS_AFTER, pos, random_value());
    else if (r < 56) send_word(CMD_LIST, pos, $urandom);
    else if (r < 64) send_word(CMD_DEL_HEAD, pos, $urandom);
    else if (r < 72) send_word(CMD_DEL_TAIL, pos, $urandom);
    else if (r < 84) send_word(CMD_DEL_AT, pos, $urandom);
    else if (r < 92) send_word(CMD_SORT_UP, pos, $urandom);
    else send_word(CMD_SORT_DN, pos, $urandom);
  endtask

  always @(negedge clk_i) begin
    int g;
    if (hold_off) begin
      out_stall_i <= 1'b1;
    end else if ($urandom_range(0, 3) == 0) begin
      g = gap_length();
      out_stall_i <= g != 0;
      if (g != 0) begin
        repeat (g) @(negedge clk_i);
        out_stall_i <= 1'b0;
      end
    end else begin
      out_stall_i <= 1'b0;
    end
  end

  initial begin
    @(posedge clk_i);
    forever begin
      @(posedge clk_i);
      if ((in_valid_i && !in_stall_o) || (out_valid_o && !out_stall_i)) idle_cycles = 0;
      else if (!hold_off) idle_cycles++;
      if (idle_cycles >= IDLE_MAX) begin
        $display("*** FAILED ***");
        $finish;
      end
    end
  end

  initial begin
    repeat (8) @(negedge clk_i);
    rst_ni <= 1'b1;
    @(negedge clk_i);
    send_word(CMD_LIST, 8'd0, 0);
    send_word(CMD_SORT_UP, 8'd0, 0);
    send_word(CMD_DEL_HEAD, 8'd0, 0);
    send_word(CMD_DEL_TAIL, 8'd0, 0);
    send_word(CMD_DEL_AT, 8'd1, 0);
    send_word(CMD_INS_AFTER, 8'd1, 5);
    send_word(CMD_INS_HEAD, 8'hff, 32'sh7fffffff);
    send_word(CMD_INS_TAIL, 8'h00, 32'sh80000000);
    send_word(CMD_INS_AFTER, 8'd0, 1);
    send_word(CMD_INS_AFTER, 8'd3, 1);
    send_word(CMD_INS_AFTER, 8'd1, -1);
    send_word(CMD_DEL_AT, 8'd0, 0);
    send_word(CMD_DEL_AT, 8'hff, 0);
    send_word(CMD_DEL_AT, 8'd2, 0);
    for (int i = 0; i < 15; i++) send_word(CMD_INS_TAIL, 8'($urandom), random_value());
    send_word(CMD_INS_HEAD, 8'd0, 7);
    send_word(CMD_INS_AFTER, 8'd16, 7);
    send_word(CMD_SORT_DN, 8'd0, 0);
    send_word(CMD_SORT_UP, 8'd0, 0);
    send_word(CMD_LIST, 8'd0, 0);
    send_word(4'd15, 8'hff, 32'hffffffff);
    hold_off = 1'b1;
    fork
      begin
        repeat (300) @(negedge clk_i);
        hold_off = 1'b0;
      end
      repeat (6) send_word(CMD_LIST, 8'd0, 0);
    join
    for (int i = 0; i < 370; i++) send_random();
    in_valid_i <= 1'b0;
    while (pending != 0) @(posedge clk_i);
    repeat (200) @(posedge clk_i);
    if (fail_count == 0) $display("*** PASSED ***");
    else $display("*** FAILED ***");
    $finish;
  end

endmodule
